### hw/rtl/tti_pkg.sv
// Shared constants, lookup table and table lookup function for the thermistor table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

   // Field widths
   localparam int ADC_W  = 10;
   localparam int TEMP_W = 12;

   // Table geometry
   localparam int STORED_ENTRIES        = 39;
   localparam int TABLE_ENTRIES_DEFAULT = 39;
   localparam int TABLE_IDX_W           = 6;

   // Temperature scale in tenths of a degree
   localparam int BASE_DECI = -400;
   localparam int STEP_DECI = 50;

   // Datapath widths: shared subtractor, numerator/quotient, final sum
   localparam int ALU_W  = 12;
   localparam int NUM_W  = 16;
   localparam int SUM_W  = 18;
   localparam int CNT_W  = 4;

   // ADC readings, one every 5 degrees from -40 C, descending
   localparam logic [ADC_W-1:0] ADC_POINTS [STORED_ENTRIES] = '{
      10'd1018, 10'd1016, 10'd1013, 10'd1008, 10'd1003, 10'd995, 10'd986, 10'd974,
      10'd960,  10'd942,  10'd920,  10'd894,  10'd864,  10'd829, 10'd790, 10'd747,
      10'd701,  10'd653,  10'd602,  10'd552,  10'd502,  10'd453, 10'd406, 10'd363,
      10'd322,  10'd286,  10'd252,  10'd222,  10'd195,  10'd172, 10'd151, 10'd133,
      10'd117,  10'd102,  10'd90,   10'd80,   10'd70,   10'd62,  10'd55
   };

   // Look up one table entry; indices past the stored entries read the last one
   function automatic logic [ADC_W-1:0] adc_point(input logic [TABLE_IDX_W-1:0] idx);
      logic [ADC_W-1:0] val;
      if (int'(idx) >= STORED_ENTRIES) begin
         val = ADC_POINTS[STORED_ENTRIES-1];
      end else begin
         val = ADC_POINTS[idx];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/tti_req_if.sv
// Input channel carrying one raw ADC sample per item.
`timescale 1ns / 1ps
`default_nettype none

interface tti_req_if;
   logic                       valid;
   logic                       ready;
   logic [tti_pkg::ADC_W-1:0]  raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/tti_rsp_if.sv
// Result channel carrying one temperature in tenths of a degree per item.
`timescale 1ns / 1ps
`default_nettype none

interface tti_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tti_pkg::TEMP_W-1:0]  temperature_deci;

   modport source (output valid, output temperature_deci, input ready);
   modport sink   (input valid, input temperature_deci, output ready);
endinterface

`default_nettype wire

### hw/rtl/thermistor_table_interpolator_top.sv
// Top level: thermistor ADC sample to temperature by table search and interpolation.
//
// Usage:
//   req_if carries one 10-bit raw ADC sample per item; rsp_if returns one signed
//   12-bit temperature in tenths of a degree Celsius per item.
//   Both channels move an item on a clock edge where valid and ready are high.
//   One item is in work at a time; req_if.ready is high only while the block is idle.
//   After accept the block searches the table from the hot end (low ADC values)
//   down to the segment k that holds the sample, sets up span and offset, divides
//   and writes the output register, so hot readings take the shortest search.
//   A flat table segment skips the divide. The search steps
//   one table entry per cycle and the divide retires one quotient bit per cycle,
//   both on one shared subtractor.
//   A stalled receiver holds the result in the output register; the block waits
//   in its output state until that register frees, and takes no new item meanwhile.
//   Synchronous reset returns the sequencer to idle and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_table_interpolator_top #(
   parameter int TABLE_ENTRIES = tti_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire     clock,
   input  wire     reset,
   tti_req_if.sink   req_if,
   tti_rsp_if.source rsp_if
);

   localparam int KW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int AW = tti_pkg::ADC_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_SPAN   = 6'b000100,
      ST_DIFF   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                          state_ff, state_in;
   logic [KW-1:0]                      k_ff, k_in;
   logic [AW-1:0]                      sample_ff, sample_in;
   logic [AW-1:0]                      span_ff, span_in;
   logic [AW-1:0]                      rem_ff, rem_in;
   logic [tti_pkg::NUM_W-1:0]          quo_ff, quo_in;
   logic [tti_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                               neg_ff, neg_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [tti_pkg::TEMP_W-1:0]  rsp_temp_ff, rsp_temp_in;

   logic [tti_pkg::TABLE_IDX_W-1:0]    lo_idx, hi_idx;
   logic [AW-1:0]                      lo_val, hi_val;
   logic signed [tti_pkg::ALU_W-1:0]   alu_a, alu_b, alu_diff;
   logic [AW:0]                        rem_shift;
   logic [AW-1:0]                      diff_mag;
   logic [tti_pkg::NUM_W-1:0]          numer;
   logic signed [tti_pkg::SUM_W-1:0]   step_w, frac_w, temp_w;
   logic                               req_take, out_free;

   // Table reads for the current segment
   assign lo_idx = tti_pkg::TABLE_IDX_W'(k_ff);
   assign hi_idx = tti_pkg::TABLE_IDX_W'(k_ff - 1'b1);
   assign lo_val = tti_pkg::adc_point(lo_idx);
   assign hi_val = tti_pkg::adc_point(hi_idx);

   assign rem_shift = {rem_ff, quo_ff[tti_pkg::NUM_W-1]};

   // Shared subtractor: search compare, span, offset and divide trial
   always_comb begin
      case (state_ff)
         ST_SEARCH: begin
            alu_a = signed'(tti_pkg::ALU_W'(lo_val));
            alu_b = signed'(tti_pkg::ALU_W'(sample_ff));
         end
         ST_SPAN: begin
            alu_a = signed'(tti_pkg::ALU_W'(hi_val));
            alu_b = signed'(tti_pkg::ALU_W'(lo_val));
         end
         ST_DIFF: begin
            alu_a = signed'(tti_pkg::ALU_W'(sample_ff));
            alu_b = signed'(tti_pkg::ALU_W'(lo_val));
         end
         ST_DIVIDE: begin
            alu_a = signed'(tti_pkg::ALU_W'(rem_shift));
            alu_b = signed'(tti_pkg::ALU_W'(span_ff));
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end
   assign alu_diff = alu_a - alu_b;

   // Offset magnitude times the step size
   assign diff_mag = alu_diff[tti_pkg::ALU_W-1] ? AW'(-alu_diff) : AW'(alu_diff);
   assign numer    = tti_pkg::NUM_W'(tti_pkg::NUM_W'(diff_mag)
                                     * tti_pkg::NUM_W'(tti_pkg::STEP_DECI));

   // Final sum: base plus segment step, minus signed fraction
   assign step_w = signed'(tti_pkg::SUM_W'(tti_pkg::SUM_W'(k_ff)
                                          * tti_pkg::SUM_W'(tti_pkg::STEP_DECI)));
   assign frac_w = signed'(tti_pkg::SUM_W'(quo_ff));
   assign temp_w = signed'(tti_pkg::SUM_W'(tti_pkg::BASE_DECI)) + step_w
                   + (neg_ff ? frac_w : -frac_w);

   assign req_take = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sample_in    = sample_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_if.raw_sample;
               k_in      = KW'(TABLE_ENTRIES - 1);
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // step down while the sample sits above the entry
            if (alu_diff[tti_pkg::ALU_W-1] && (k_ff > KW'(1))) begin
               k_in = k_ff - 1'b1;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in  = AW'(alu_diff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in = alu_diff[tti_pkg::ALU_W-1];
            rem_in = '0;
            cnt_in = '0;
            if (span_ff == '0) begin
               quo_in   = '0;
               state_in = ST_FINISH;
            end else begin
               quo_in   = numer;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one restoring step per cycle
            if (!alu_diff[tti_pkg::ALU_W-1]) begin
               rem_in = AW'(alu_diff);
               quo_in = {quo_ff[tti_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = AW'(rem_shift);
               quo_in = {quo_ff[tti_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_temp_in  = temp_w[tti_pkg::TEMP_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      sample_ff   <= sample_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign req_if.ready            = (state_ff == ST_IDLE);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.temperature_deci = rsp_temp_ff;

   // Accepted item starts the search
   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SEARCH))
      else $error("accepted item did not start the search");

   // Segment index never reaches zero while searching
   a_search_index_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (k_ff != '0))
      else $error("search index fell to zero");

   // Divider remainder stays below the span
   a_divide_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < span_ff))
      else $error("divider remainder out of range");

   // A new result appears only out of the output state
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the output state");

endmodule

`default_nettype wire
